[hdl/rlpe_pkg.sv]
// ----------------------------------------------------------------------------
// rlpe_pkg
// shared types and constants for the regex literal prefix extraction unit
// ----------------------------------------------------------------------------
package rlpe_pkg;

  localparam logic [1:0] CMD_FLAG    = 2'd0;
  localparam logic [1:0] CMD_PATTERN = 2'd1;
  localparam logic [1:0] CMD_END     = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_M      = 8'h6d;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [1:0] {
    PH_FLAGS   = 2'd0,
    PH_SCAN    = 2'd1,
    PH_ESCAPE  = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       last;
    logic       pure_prefix;
  } out_item_t;

  typedef struct packed {
    logic is_meta;
    logic is_alnum;
    logic is_space;
    logic is_opt;
    logic is_bslash;
    logic is_caret;
    logic is_hash;
    logic is_m;
    logic is_x;
  } ch_class_t;

endpackage

[hdl/rlpe_class.sv]
// ----------------------------------------------------------------------------
// rlpe_class
// byte classifier: metacharacters, alphanumerics, whitespace and markers
// ----------------------------------------------------------------------------
module rlpe_class (
  input  logic [7:0]          ch,
  output rlpe_pkg::ch_class_t cls
);

  always_comb begin
    cls.is_meta   = (ch inside {rlpe_pkg::CH_CARET, rlpe_pkg::CH_DOLLAR,
                                rlpe_pkg::CH_DOT, rlpe_pkg::CH_LBRACK,
                                rlpe_pkg::CH_PIPE, rlpe_pkg::CH_LPAREN,
                                rlpe_pkg::CH_RPAREN, rlpe_pkg::CH_PLUS,
                                rlpe_pkg::CH_LBRACE});
    cls.is_alnum  = (ch inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39]});
    cls.is_space  = (ch inside {rlpe_pkg::CH_SPACE, [8'h09:8'h0d]});
    cls.is_opt    = (ch inside {rlpe_pkg::CH_STAR, rlpe_pkg::CH_QMARK});
    cls.is_bslash = (ch == rlpe_pkg::CH_BSLASH);
    cls.is_caret  = (ch == rlpe_pkg::CH_CARET);
    cls.is_hash   = (ch == rlpe_pkg::CH_HASH);
    cls.is_m      = (ch == rlpe_pkg::CH_M);
    cls.is_x      = (ch == rlpe_pkg::CH_X);
  end

endmodule

[hdl/rlpe_core.sv]
// ----------------------------------------------------------------------------
// rlpe_core
// scan state machine: holds one literal back and decides each result item
// ----------------------------------------------------------------------------
module rlpe_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  rlpe_pkg::in_item_t  item,
  output logic                res_valid,
  output rlpe_pkg::out_item_t res
);

  rlpe_pkg::ch_class_t cls;
  rlpe_pkg::phase_t    phase_r, phase_nxt;
  logic                ext_r, ext_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                hv_r, hv_nxt;
  logic                pn_r, pn_nxt;
  logic                cv;

  rlpe_class u_class (
    .ch  (item.ch),
    .cls (cls)
  );

  // next state
  always_comb begin
    phase_nxt = phase_r;
    ext_nxt   = ext_r;
    held_nxt  = held_r;
    hv_nxt    = hv_r;
    pn_nxt    = pn_r;
    case (item.command)
      rlpe_pkg::CMD_END: begin
        phase_nxt = rlpe_pkg::PH_FLAGS;
        ext_nxt   = 1'b0;
        held_nxt  = 8'h00;
        hv_nxt    = 1'b0;
        pn_nxt    = 1'b0;
      end
      rlpe_pkg::CMD_FLAG: begin
        if (phase_r == rlpe_pkg::PH_FLAGS) begin
          if (cls.is_x) begin
            ext_nxt = 1'b1;
          end else if (!cls.is_m) begin
            phase_nxt = rlpe_pkg::PH_STOPPED;
          end
        end
      end
      rlpe_pkg::CMD_PATTERN: begin
        case (phase_r)
          rlpe_pkg::PH_FLAGS: begin
            phase_nxt = cls.is_caret ? rlpe_pkg::PH_SCAN : rlpe_pkg::PH_STOPPED;
          end
          rlpe_pkg::PH_SCAN: begin
            if (cls.is_opt) begin
              hv_nxt    = 1'b0;
              phase_nxt = rlpe_pkg::PH_STOPPED;
            end else if (cls.is_bslash) begin
              phase_nxt = rlpe_pkg::PH_ESCAPE;
            end else if (cls.is_meta || (ext_r && cls.is_hash)) begin
              phase_nxt = rlpe_pkg::PH_STOPPED;
              hv_nxt    = 1'b0;
              pn_nxt    = pn_r | hv_r;
            end else if (!(ext_r && cls.is_space)) begin
              held_nxt = item.ch;
              hv_nxt   = 1'b1;
              pn_nxt   = pn_r | hv_r;
            end
          end
          rlpe_pkg::PH_ESCAPE: begin
            if (cls.is_alnum) begin
              phase_nxt = rlpe_pkg::PH_STOPPED;
              hv_nxt    = 1'b0;
              pn_nxt    = pn_r | hv_r;
            end else begin
              phase_nxt = rlpe_pkg::PH_SCAN;
              held_nxt  = item.ch;
              hv_nxt    = 1'b1;
              pn_nxt    = pn_r | hv_r;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // result decode
  always_comb begin
    res_valid       = 1'b0;
    cv              = 1'b0;
    res.last        = 1'b0;
    res.pure_prefix = 1'b0;
    case (item.command)
      rlpe_pkg::CMD_END: begin
        res_valid = 1'b1;
        res.last  = 1'b1;
        if (phase_r == rlpe_pkg::PH_SCAN) begin
          cv              = hv_r;
          res.pure_prefix = hv_r | pn_r;
        end else if (phase_r == rlpe_pkg::PH_ESCAPE) begin
          cv = hv_r;
        end
      end
      rlpe_pkg::CMD_PATTERN: begin
        case (phase_r)
          rlpe_pkg::PH_SCAN: begin
            if (!cls.is_opt && !cls.is_bslash && !(ext_r && cls.is_space &&
                !cls.is_meta && !cls.is_hash)) begin
              res_valid = hv_r;
              cv        = hv_r;
            end
          end
          rlpe_pkg::PH_ESCAPE: begin
            res_valid = hv_r;
            cv        = hv_r;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    res.char_valid = cv;
    res.out_char   = cv ? held_r : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rlpe_pkg::PH_FLAGS;
      ext_r   <= 1'b0;
      held_r  <= 8'h00;
      hv_r    <= 1'b0;
      pn_r    <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      ext_r   <= ext_nxt;
      held_r  <= held_nxt;
      hv_r    <= hv_nxt;
      pn_r    <= pn_nxt;
    end
  end

endmodule

[hdl/regex_literal_prefix_extract_unit.sv]
// ----------------------------------------------------------------------------
// regex_literal_prefix_extract_unit
// extracts the literal prefix of an anchored regular expression, one byte
// per item
// ----------------------------------------------------------------------------
// Feed the flag bytes, then the pattern bytes, then an end item. The unit
// takes one item per clock while in_stall is low; an accepted item lands in
// the input register, the scan state machine decodes it, and its result item
// is registered into the output register and presented on the out side. A
// pattern byte yields a result only when a held literal is confirmed; the end
// item always yields one result with last set and returns the unit to its
// reset state. The scan machine updates its state as each item goes on, so a
// stall on the result side backs up into in_stall directly.
module regex_literal_prefix_extract_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rlpe_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rlpe_pkg::out_item_t out_item
);

  logic                in_valid_r;
  rlpe_pkg::in_item_t  in_item_r;
  logic                out_valid_r;
  rlpe_pkg::out_item_t out_item_r;
  logic                advance;
  logic                go;
  logic                res_valid;
  rlpe_pkg::out_item_t res;

  assign advance  = !out_valid_r || !out_stall;
  assign go       = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  rlpe_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
